/* design/hcbd_pkg.sv */
// ----------------------------------------------------------------------------
// hcbd_pkg
// Shared types and constants of the prefix-code tree build and decode block.
// ----------------------------------------------------------------------------
package hcbd_pkg;

  localparam int MAX_ENTRIES = 1024;
  localparam int MAX_NODES   = 2048;
  localparam int MAX_LEN     = 32;

  localparam int NODE_W  = $clog2(MAX_NODES);
  localparam int CNT_W   = $clog2(MAX_NODES + 1);
  localparam int ENTRY_W = 10;
  localparam int LEN_W   = 6;
  localparam int LVL_W   = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int STAT_W  = 3;

  typedef enum logic [STAT_W-1:0] {
    ST_INS_OK   = 3'd0,
    ST_INS_OVF  = 3'd1,
    ST_DEC_PEND = 3'd2,
    ST_DEC_DONE = 3'd3,
    ST_DEC_ERR  = 3'd4
  } status_e;

  // one node memory word
  typedef struct packed {
    logic [NODE_W-1:0]  left;
    logic [NODE_W-1:0]  right;
    logic               leaf;
    logic               full;
    logic [ENTRY_W-1:0] entry;
  } node_t;

  localparam int NODE_BITS = $bits(node_t);

  typedef enum logic [4:0] {
    C_NONE,
    C_DEC_START,
    C_DEC_STEP,
    C_DEC_DONE,
    C_DEC_PEND,
    C_DEC_ERR,
    C_INS_START,
    C_INS_OK,
    C_INS_FAIL,
    C_SK_ROOT,
    C_SK_LEFT,
    C_SK_HITL,
    C_SK_UP,
    C_SK_RIGHT,
    C_SK_HITR,
    C_CHAIN_INIT,
    C_CHAIN_EMPTY,
    C_CHAIN_WR,
    C_RD_HIT,
    C_LINK_WR,
    C_PR_RDN,
    C_PR_RDL,
    C_PR_RDR,
    C_PR_WR
  } cmd_e;

  // datapath flags seen by the controller
  typedef struct packed {
    logic tree_empty;
    logic len_bad;
    logic c_ok;
    logic leaf;
    logic sk_skip;
    logic sk_bad;
    logic sk_lok;
    logic up_root;
    logic up_side;
    logic up_rok;
    logic need_ok;
    logic empty_ok;
    logic chain_last;
    logic no_link;
    logic both_ok;
    logic rd_full;
    logic dep_zero;
  } flags_t;

endpackage

/* design/hcbd_node_ram.sv */
// ----------------------------------------------------------------------------
// hcbd_node_ram
// Single-port node memory, registered read data held when not reading.
// ----------------------------------------------------------------------------
module hcbd_node_ram #(
  parameter int DEPTH = 2048,
  parameter int WIDTH = 34
) (
  input  logic                     clk_i,
  input  logic                     re_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* design/hcbd_datapath.sv */
// ----------------------------------------------------------------------------
// hcbd_datapath
// Tree registers, search stack, node memory and result registers.
// ----------------------------------------------------------------------------
module hcbd_datapath (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  hcbd_pkg::cmd_e               cmd_i,
  input  logic [hcbd_pkg::ENTRY_W-1:0] entry_in_i,
  input  logic [hcbd_pkg::LEN_W-1:0]   code_length_i,
  input  logic                         bit_in_i,
  output hcbd_pkg::flags_t             flags_o,
  output logic [hcbd_pkg::STAT_W-1:0]  status_o,
  output logic [hcbd_pkg::ENTRY_W-1:0] entry_out_o,
  output logic [hcbd_pkg::LEN_W-1:0]   bits_used_o
);
  import hcbd_pkg::*;

  logic [CNT_W-1:0]   nodes_used_q;
  logic [NODE_W-1:0]  walk_node_q;
  logic [LEN_W-1:0]   walk_depth_q;
  logic [ENTRY_W-1:0] entry_q;
  logic [LEN_W-1:0]   len_q;
  logic               bit_q;
  logic [NODE_W-1:0]  cur_q;
  logic [LEN_W-1:0]   dep_q;
  logic               as_child_q;
  logic [NODE_W-1:0]  path_q  [MAX_LEN];
  logic [NODE_W-1:0]  rstk_q  [MAX_LEN];
  logic [MAX_LEN-1:0] side_q;
  logic [MAX_LEN-1:0] rok_q;
  logic [NODE_W-1:0]  hit_node_q;
  logic               hit_side_q;
  logic [LEN_W-1:0]   hit_dep_q;
  logic [NODE_W-1:0]  first_q;
  logic [LEN_W:0]     rem_q;
  logic               no_link_q;
  node_t              nword_q;
  logic [STAT_W-1:0]  status_q;
  logic [ENTRY_W-1:0] eout_q;
  logic [LEN_W-1:0]   used_q;

  node_t              rdata;
  node_t              wdata;
  logic [NODE_BITS-1:0] rdata_raw;
  logic               re, we;
  logic [NODE_W-1:0]  addr;
  logic [NODE_W-1:0]  dec_c;
  logic [LVL_W-1:0]   lvl, plvl;
  logic [LEN_W-1:0]   pdep;
  logic [LEN_W-1:0]   need;
  logic [CNT_W-1:0]   room;
  logic               chain_last;

  function automatic logic link_ok(logic [NODE_W-1:0] c, logic [CNT_W-1:0] used);
    return (c != '0) && ({{(CNT_W-NODE_W){1'b0}}, c} < used);
  endfunction

  assign rdata      = node_t'(rdata_raw);
  assign lvl        = dep_q[LVL_W-1:0];
  assign pdep       = dep_q - LEN_W'(1);
  assign plvl       = pdep[LVL_W-1:0];
  assign dec_c      = bit_q ? rdata.right : rdata.left;
  assign need       = len_q - hit_dep_q;
  assign room       = CNT_W'(MAX_NODES) - nodes_used_q;
  assign chain_last = (rem_q == (LEN_W+1)'(1));

  always_comb begin
    flags_o.tree_empty = (nodes_used_q == '0);
    flags_o.len_bad    = (len_q == '0) || ({1'b0, len_q} > (LEN_W+1)'(MAX_LEN)) ||
                         ({1'b0, entry_q} >= (ENTRY_W+1)'(MAX_ENTRIES));
    flags_o.c_ok       = link_ok(dec_c, nodes_used_q);
    flags_o.leaf       = rdata.leaf;
    flags_o.sk_skip    = as_child_q && rdata.full;
    flags_o.sk_bad     = (dep_q >= len_q) || rdata.leaf;
    flags_o.sk_lok     = link_ok(rdata.left, nodes_used_q);
    flags_o.up_root    = (dep_q == '0);
    flags_o.up_side    = side_q[plvl];
    flags_o.up_rok     = rok_q[plvl];
    flags_o.need_ok    = ({{(CNT_W-LEN_W){1'b0}}, need} <= room);
    flags_o.empty_ok   = ((CNT_W+1)'(len_q) + (CNT_W+1)'(1) <= (CNT_W+1)'(MAX_NODES));
    flags_o.chain_last = chain_last;
    flags_o.no_link    = no_link_q;
    flags_o.both_ok    = link_ok(rdata.left, nodes_used_q) &&
                         link_ok(rdata.right, nodes_used_q);
    flags_o.rd_full    = rdata.full;
    flags_o.dep_zero   = (dep_q == '0);
  end

  // memory port
  always_comb begin
    re    = 1'b0;
    we    = 1'b0;
    addr  = cur_q;
    wdata = rdata;
    case (cmd_i)
      C_DEC_START: begin re = 1'b1; addr = walk_node_q; end
      C_DEC_STEP:  begin re = 1'b1; addr = dec_c; end
      C_SK_ROOT:   begin re = 1'b1; addr = cur_q; end
      C_SK_LEFT:   begin re = 1'b1; addr = rdata.left; end
      C_SK_RIGHT:  begin re = 1'b1; addr = rstk_q[plvl]; end
      C_CHAIN_WR: begin
        we          = 1'b1;
        addr        = nodes_used_q[NODE_W-1:0];
        wdata.left  = chain_last ? '0 : NODE_W'(nodes_used_q + CNT_W'(1));
        wdata.right = '0;
        wdata.leaf  = chain_last;
        wdata.full  = chain_last;
        wdata.entry = chain_last ? entry_q : '0;
      end
      C_RD_HIT:    begin re = 1'b1; addr = hit_node_q; end
      C_LINK_WR: begin
        we   = 1'b1;
        addr = hit_node_q;
        if (hit_side_q) begin
          wdata.right = first_q;
        end else begin
          wdata.left = first_q;
        end
      end
      C_PR_RDN:    begin re = 1'b1; addr = path_q[lvl]; end
      C_PR_RDL:    begin re = 1'b1; addr = rdata.left; end
      C_PR_RDR:    begin re = 1'b1; addr = nword_q.right; end
      C_PR_WR: begin
        we         = 1'b1;
        addr       = path_q[lvl];
        wdata      = nword_q;
        wdata.full = 1'b1;
      end
      default: begin
        re = 1'b0;
      end
    endcase
  end

  hcbd_node_ram #(
    .DEPTH(MAX_NODES),
    .WIDTH(NODE_BITS)
  ) u_ram (
    .clk_i  (clk_i),
    .re_i   (re),
    .we_i   (we),
    .addr_i (addr),
    .wdata_i(wdata),
    .rdata_o(rdata_raw)
  );

  // control-side registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nodes_used_q <= '0;
      walk_node_q  <= '0;
      walk_depth_q <= '0;
    end else begin
      case (cmd_i)
        C_INS_START, C_DEC_ERR, C_DEC_DONE: begin
          walk_node_q  <= '0;
          walk_depth_q <= '0;
        end
        C_DEC_PEND: begin
          walk_node_q  <= cur_q;
          walk_depth_q <= walk_depth_q + LEN_W'(1);
        end
        C_CHAIN_WR: nodes_used_q <= nodes_used_q + CNT_W'(1);
        default: begin
          walk_node_q <= walk_node_q;
        end
      endcase
    end
  end

  // payload and scratch registers
  always_ff @(posedge clk_i) begin
    case (cmd_i)
      C_DEC_START: bit_q <= bit_in_i;
      C_DEC_STEP:  cur_q <= dec_c;
      C_INS_START: begin
        entry_q    <= entry_in_i;
        len_q      <= code_length_i;
        cur_q      <= '0;
        dep_q      <= '0;
        as_child_q <= 1'b0;
        no_link_q  <= 1'b0;
      end
      C_SK_LEFT, C_SK_HITL: begin
        path_q[lvl] <= cur_q;
        rstk_q[lvl] <= rdata.right;
        rok_q[lvl]  <= link_ok(rdata.right, nodes_used_q);
        side_q[lvl] <= 1'b0;
        if (cmd_i == C_SK_LEFT) begin
          cur_q      <= rdata.left;
          dep_q      <= dep_q + LEN_W'(1);
          as_child_q <= 1'b1;
        end else begin
          hit_node_q <= cur_q;
          hit_side_q <= 1'b0;
          hit_dep_q  <= dep_q;
        end
      end
      C_SK_UP: dep_q <= pdep;
      C_SK_RIGHT: begin
        side_q[plvl] <= 1'b1;
        cur_q        <= rstk_q[plvl];
        as_child_q   <= 1'b1;
      end
      C_SK_HITR: begin
        hit_node_q <= path_q[plvl];
        hit_side_q <= 1'b1;
        hit_dep_q  <= pdep;
      end
      C_CHAIN_INIT: begin
        rem_q   <= {1'b0, need};
        first_q <= nodes_used_q[NODE_W-1:0];
      end
      C_CHAIN_EMPTY: begin
        rem_q     <= {1'b0, len_q} + (LEN_W+1)'(1);
        no_link_q <= 1'b1;
      end
      C_CHAIN_WR: rem_q <= rem_q - (LEN_W+1)'(1);
      C_LINK_WR:  dep_q <= hit_dep_q;
      C_PR_RDL:   nword_q <= rdata;
      C_PR_WR: begin
        if (dep_q != '0) begin
          dep_q <= pdep;
        end
      end
      default: begin
        bit_q <= bit_q;
      end
    endcase
  end

  // result register
  always_ff @(posedge clk_i) begin
    case (cmd_i)
      C_INS_OK:   begin status_q <= ST_INS_OK;   eout_q <= '0; used_q <= '0; end
      C_INS_FAIL: begin status_q <= ST_INS_OVF;  eout_q <= '0; used_q <= '0; end
      C_DEC_ERR:  begin status_q <= ST_DEC_ERR;  eout_q <= '0; used_q <= '0; end
      C_DEC_PEND: begin status_q <= ST_DEC_PEND; eout_q <= '0; used_q <= '0; end
      C_DEC_DONE: begin
        status_q <= ST_DEC_DONE;
        eout_q   <= rdata.entry;
        used_q   <= walk_depth_q + LEN_W'(1);
      end
      default: begin
        status_q <= status_q;
      end
    endcase
  end

  assign status_o    = status_q;
  assign entry_out_o = eout_q;
  assign bits_used_o = used_q;

`ifndef ASSERT_OFF
  a_walk_root: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (walk_depth_q != '0) |-> (walk_node_q != '0))
    else $error("walk depth nonzero at root");
  a_chain_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i == C_CHAIN_WR) |-> (nodes_used_q < CNT_W'(MAX_NODES)))
    else $error("chain write beyond node memory");
  a_nodes_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i != C_CHAIN_WR) |=> (nodes_used_q == $past(nodes_used_q)))
    else $error("node count moved without a chain write");
`endif

endmodule

/* design/hcbd_ctrl.sv */
// ----------------------------------------------------------------------------
// hcbd_ctrl
// Sequencer for decode steps, tree search, chain allocation and full marks.
// ----------------------------------------------------------------------------
module hcbd_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             op_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  hcbd_pkg::flags_t flags_i,
  output hcbd_pkg::cmd_e   cmd_o
);
  import hcbd_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_DEC_EV1, S_DEC_EV2, S_DEC_ERR, S_INS_CHK, S_SK_EV, S_SK_UP,
    S_NEED, S_CHAIN, S_LINK_RD, S_LINK_WR, S_PR_RDN, S_PR_EVN, S_PR_EVL,
    S_PR_EVR, S_INS_OK, S_INS_FAIL
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;
  cmd_e   cmd;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    cmd     = C_NONE;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (op_i) begin
            cmd     = C_DEC_START;
            state_d = flags_i.tree_empty ? S_DEC_ERR : S_DEC_EV1;
          end else begin
            cmd     = C_INS_START;
            state_d = S_INS_CHK;
          end
        end
      end
      S_DEC_EV1: begin
        if (flags_i.c_ok) begin
          cmd     = C_DEC_STEP;
          state_d = S_DEC_EV2;
        end else begin
          state_d = S_DEC_ERR;
        end
      end
      S_DEC_EV2: begin
        if (out_free) begin
          cmd     = flags_i.leaf ? C_DEC_DONE : C_DEC_PEND;
          state_d = S_IDLE;
        end
      end
      S_DEC_ERR: begin
        if (out_free) begin
          cmd     = C_DEC_ERR;
          state_d = S_IDLE;
        end
      end
      S_INS_CHK: begin
        if (flags_i.len_bad) begin
          state_d = S_INS_FAIL;
        end else if (flags_i.tree_empty) begin
          if (flags_i.empty_ok) begin
            cmd     = C_CHAIN_EMPTY;
            state_d = S_CHAIN;
          end else begin
            state_d = S_INS_FAIL;
          end
        end else begin
          cmd     = C_SK_ROOT;
          state_d = S_SK_EV;
        end
      end
      S_SK_EV: begin
        if (flags_i.sk_skip || flags_i.sk_bad) begin
          state_d = S_SK_UP;
        end else if (!flags_i.sk_lok) begin
          cmd     = C_SK_HITL;
          state_d = S_NEED;
        end else begin
          cmd = C_SK_LEFT;
        end
      end
      S_SK_UP: begin
        if (flags_i.up_root) begin
          state_d = S_INS_FAIL;
        end else if (flags_i.up_side) begin
          cmd = C_SK_UP;
        end else if (!flags_i.up_rok) begin
          cmd     = C_SK_HITR;
          state_d = S_NEED;
        end else begin
          cmd     = C_SK_RIGHT;
          state_d = S_SK_EV;
        end
      end
      S_NEED: begin
        if (flags_i.need_ok) begin
          cmd     = C_CHAIN_INIT;
          state_d = S_CHAIN;
        end else begin
          state_d = S_INS_FAIL;
        end
      end
      S_CHAIN: begin
        cmd = C_CHAIN_WR;
        if (flags_i.chain_last) begin
          state_d = flags_i.no_link ? S_INS_OK : S_LINK_RD;
        end
      end
      S_LINK_RD: begin
        cmd     = C_RD_HIT;
        state_d = S_LINK_WR;
      end
      S_LINK_WR: begin
        cmd     = C_LINK_WR;
        state_d = S_PR_RDN;
      end
      S_PR_RDN: begin
        cmd     = C_PR_RDN;
        state_d = S_PR_EVN;
      end
      S_PR_EVN: begin
        if (flags_i.both_ok) begin
          cmd     = C_PR_RDL;
          state_d = S_PR_EVL;
        end else begin
          state_d = S_INS_OK;
        end
      end
      S_PR_EVL: begin
        if (flags_i.rd_full) begin
          cmd     = C_PR_RDR;
          state_d = S_PR_EVR;
        end else begin
          state_d = S_INS_OK;
        end
      end
      S_PR_EVR: begin
        if (flags_i.rd_full) begin
          cmd     = C_PR_WR;
          state_d = flags_i.dep_zero ? S_INS_OK : S_PR_RDN;
        end else begin
          state_d = S_INS_OK;
        end
      end
      S_INS_OK: begin
        if (out_free) begin
          cmd     = C_INS_OK;
          state_d = S_IDLE;
        end
      end
      S_INS_FAIL: begin
        if (out_free) begin
          cmd     = C_INS_FAIL;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    if (cmd == C_INS_OK || cmd == C_INS_FAIL || cmd == C_DEC_ERR ||
        cmd == C_DEC_DONE || cmd == C_DEC_PEND) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign cmd_o       = cmd;

`ifndef ASSERT_OFF
  a_fin_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd == C_INS_OK || cmd == C_INS_FAIL || cmd == C_DEC_ERR ||
     cmd == C_DEC_DONE || cmd == C_DEC_PEND) |-> out_free)
    else $error("result written over a waiting item");
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q != S_IDLE))
    else $error("accepted item not started");
  a_fin_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd == C_DEC_DONE || cmd == C_DEC_PEND) |=> out_valid_o)
    else $error("decode result lost");
`endif

endmodule

/* design/huffman_codebook_build_decode_top.sv */
// ----------------------------------------------------------------------------
// huffman_codebook_build_decode_top
// Prefix-code tree builder and bit-serial decoder on a shared node memory.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one item: op_i = 0 inserts
//   entry_in_i with code_length_i, op_i = 1 feeds bit_in_i to the decoder.
//   Output channel (out_valid_o/out_ready_i) returns one item per input:
//   status_o, entry_out_o and bits_used_o.
//   Sequence: one item at a time; a new item is taken the cycle after the last
//   result is registered. A decode bit reads the current node, then the chosen
//   child, and then registers its result; on an empty tree it goes straight
//   to the error result. An insert runs its checks, visits nodes and climbs
//   back levels in the search, checks for room, allocates one node per step,
//   reads and writes the link, reads and tests nodes while full marks climb
//   the path, and registers the result; the node memory's single port sets
//   this order.
//   Reset: the tree is empty and the walk sits at the root. The node memory
//   is not cleared; only allocated nodes' contents are ever used.
//   Stall: a finished result waits in the output register while a new item
//   is taken; the next result is held until out_ready_i frees that register.
// ----------------------------------------------------------------------------
module huffman_codebook_build_decode_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         op_i,
  input  logic [hcbd_pkg::ENTRY_W-1:0] entry_in_i,
  input  logic [hcbd_pkg::LEN_W-1:0]   code_length_i,
  input  logic                         bit_in_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [hcbd_pkg::STAT_W-1:0]  status_o,
  output logic [hcbd_pkg::ENTRY_W-1:0] entry_out_o,
  output logic [hcbd_pkg::LEN_W-1:0]   bits_used_o
);
  import hcbd_pkg::*;

  cmd_e   cmd;     // one command per cycle from the sequencer
  flags_t flags;   // compare results back from the datapath

  // sequencer: handshakes and the step order of each item
  hcbd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .op_i       (op_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .flags_i    (flags),
    .cmd_o      (cmd)
  );

  // datapath: node memory, search stack, walk and result registers
  hcbd_datapath u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .entry_in_i   (entry_in_i),
    .code_length_i(code_length_i),
    .bit_in_i     (bit_in_i),
    .flags_o      (flags),
    .status_o     (status_o),
    .entry_out_o  (entry_out_o),
    .bits_used_o  (bits_used_o)
  );

endmodule
